/* rtl/assert_macros.svh */
// Assertion macros shared by the track position LED matrix RTL.
// Self-contained; each RTL file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// A consequence that must hold in the same cycle as its cause.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// A consequence that must hold in the cycle after its cause.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/tplm_pkg.sv */
// Package of the track position LED matrix: widths, codes, reset values
// and the request structs between the sequencer, divider and frame buffer.
// No dependencies.
`default_nettype none

package tplm_pkg;

    localparam int TRACKS   = 16;
    localparam int ROWS     = 8;
    localparam int PIX_W    = 8;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int FB_DEPTH = 2 * 2 * ROWS;
    localparam int FB_AW    = $clog2(FB_DEPTH);

    // Shared divider: 32-bit dividend, divisor up to the 12-bit resolution.
    localparam int DIV_DW = 32;
    localparam int DIV_SW = 12;
    localparam int DIV_CW = $clog2(DIV_DW + 1);

    // Input kinds.
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_TRACK = 2'd1;
    localparam logic [1:0] KIND_SCAN  = 2'd2;

    // Panel variants.
    localparam logic [1:0] VAR_OFF     = 2'd0;
    localparam logic [1:0] VAR_PLAIN   = 2'd1;
    localparam logic [1:0] VAR_INV_ALL = 2'd2;

    // Display modes.
    localparam logic [2:0] MODE_METER     = 3'd0;
    localparam logic [2:0] MODE_ROT_METER = 3'd1;
    localparam logic [2:0] MODE_DOT       = 3'd2;
    localparam logic [2:0] MODE_ROT_DOT   = 3'd3;
    localparam logic [2:0] MODE_LOGO      = 3'd4;
    localparam logic [2:0] MODE_LOGO_BEAT = 3'd5;
    localparam logic [2:0] MODE_POS_TRK   = 3'd6;
    localparam logic [2:0] MODE_ROT_PT    = 3'd7;

    // Register indexes.
    localparam logic [2:0] REG_VARIANT = 3'd0;
    localparam logic [2:0] REG_MODE    = 3'd1;
    localparam logic [2:0] REG_LOGO_L  = 3'd2;
    localparam logic [2:0] REG_LOGO_R  = 3'd3;
    localparam logic [2:0] REG_SPM     = 3'd4;
    localparam logic [2:0] REG_PPQ     = 3'd5;
    localparam logic [2:0] REG_RRC     = 3'd6;

    // Register reset values.
    localparam logic [7:0]  RST_SPM = 8'd15;
    localparam logic [11:0] RST_PPQ = 12'd384;
    localparam logic        RST_RRC = 1'b1;

    typedef logic [FB_AW-1:0] t_fb_addr;
    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic     clr;
        logic     re;
        logic     we;
        t_fb_addr addr;
        t_pix     data;
    } t_fb_req;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quotient;
        logic [DIV_SW-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

/* rtl/tplm_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on tplm_pkg.
`default_nettype none

module tplm_divider
    import tplm_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_CW-1:0] r_cnt;
    logic              r_done;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_SW-1:0] r_rem;
    logic [DIV_SW-1:0] r_div;

    logic [DIV_SW:0] trial;
    logic [DIV_SW:0] diff;
    logic            ge;
    logic            load;

    assign load  = i_req.start && (r_cnt == '0);
    assign trial = {r_rem, r_quo[DIV_DW-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (load) begin
                r_cnt <= DIV_CW'(DIV_DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_DW-2:0], ge};
            r_rem <= ge ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
        end
    end

    assign o_rsp.busy      = (r_cnt != '0);
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

/* rtl/tplm_fbuf.sv */
// Frame buffer: single-port memory with registered read data and one
// valid bit per entry, so that reset and a frame clear need no clearing pass.
// Depends on tplm_pkg.
`default_nettype none

module tplm_fbuf
    import tplm_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_fb_req i_req,
    output t_pix    o_rdata
);

    t_pix                r_mem [FB_DEPTH];
    logic [FB_DEPTH-1:0] r_valid;
    t_pix                r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.data;
        end
        if (i_req.re) begin
            r_rdata <= r_valid[i_req.addr] ? r_mem[i_req.addr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/track_position_led_matrix.sv */
// Top level of the track position LED matrix: sequencer, registers, ports.
// Depends on tplm_pkg, tplm_divider, tplm_fbuf and assert_macros.svh.
`default_nettype none

// This block drives a 16 by 8 two-colour LED panel that shows the play
// position of sixteen sequencer tracks. Requests arrive on the slave stream:
// a frame start clears the frame buffer or, in the logo modes, loads the
// logo into it, one buffer byte per cycle; a track request divides eight
// times its step by its length plus one through the shared divider and then
// draws its marks, each read-modify-write a buffer read and then a write; a
// scan tick advances the multiplex row, works out the beat flash with up to
// two passes of the same divider, reads four buffer bytes and presents one
// result on the master stream, after any wait for the output register to
// empty. The divider yields one quotient bit per cycle, and the buffer has
// a single port; the block takes one request at a time and is not ready
// while it works. A finished result waits in the output register while the
// next request is taken, and only a further scan tick waits for it to go.
// With the panel disabled, for a track request in the logo modes, and for
// the unused kind, a request is taken and dropped. The frame buffer is clear
// straight out of reset through per-entry valid bits, so there is no
// clearing pass. Registers sit on the APB port at byte address eight times
// their index.
module track_position_led_matrix
    import tplm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Slave stream, tdata from bit 0: track[3:0], step[11:4], length[19:12],
    // vu_level[27:20], muted[28], selected[29], running[30],
    // beat_step[38:31], tick[70:39], zero[71].
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [71:0] i_s_tdata,
    // tuser from bit 0: kind[1:0].
    input  wire  [1:0]  i_s_tuser,
    // Master stream, tdata from bit 0: column_drive[7:0], green_left[15:8],
    // green_right[23:16], red_left[31:24], red_right[39:32].
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOGO,
        ST_POS,
        ST_TRK_PLAN,
        ST_TRK_WR,
        ST_SCAN_D1,
        ST_SCAN_D2,
        ST_SCAN_RD,
        ST_SCAN_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_MARK_A,
        OP_MARK_B,
        OP_VU,
        OP_DONE
    } t_op;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [1:0]  r_variant;
    logic [2:0]  r_mode;
    logic [63:0] r_logo_l;
    logic [63:0] r_logo_r;
    logic [7:0]  r_spm;
    logic [11:0] r_ppq;
    logic        r_rrc;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= VAR_OFF;
            r_mode    <= MODE_METER;
            r_logo_l  <= '0;
            r_logo_r  <= '0;
            r_spm     <= RST_SPM;
            r_ppq     <= RST_PPQ;
            r_rrc     <= RST_RRC;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_VARIANT: r_variant <= pwdata[1:0];
                REG_MODE:    r_mode    <= pwdata[2:0];
                REG_LOGO_L:  r_logo_l  <= pwdata;
                REG_LOGO_R:  r_logo_r  <= pwdata;
                REG_SPM:     r_spm     <= pwdata[7:0];
                REG_PPQ:     r_ppq     <= pwdata[11:0];
                REG_RRC:     r_rrc     <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_VARIANT: prdata = {62'd0, r_variant};
            REG_MODE:    prdata = {61'd0, r_mode};
            REG_LOGO_L:  prdata = r_logo_l;
            REG_LOGO_R:  prdata = r_logo_r;
            REG_SPM:     prdata = {56'd0, r_spm};
            REG_PPQ:     prdata = {52'd0, r_ppq};
            REG_RRC:     prdata = {63'd0, r_rrc};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input request fields and the latched copy used while working.
    // ------------------------------------------------------------------
    logic [1:0]  in_kind;
    logic [3:0]  in_track;
    logic [7:0]  in_step;
    logic [7:0]  in_len;
    logic        in_run;
    logic [7:0]  in_refstep;

    assign in_kind    = i_s_tuser[1:0];
    assign in_track   = i_s_tdata[3:0];
    assign in_step    = i_s_tdata[11:4];
    assign in_len     = i_s_tdata[19:12];
    assign in_run     = i_s_tdata[30];
    assign in_refstep = i_s_tdata[38:31];

    logic [3:0]  r_track;
    logic [7:0]  r_vu;
    logic        r_muted;
    logic        r_sel;
    logic [7:0]  r_refstep;
    logic [31:0] r_tick;

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_track   <= in_track;
            r_vu      <= i_s_tdata[27:20];
            r_muted   <= i_s_tdata[28];
            r_sel     <= i_s_tdata[29];
            r_refstep <= in_refstep;
            r_tick    <= i_s_tdata[70:39];
        end
    end

    // ------------------------------------------------------------------
    // Shared divider and frame buffer.
    // ------------------------------------------------------------------
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_fb_req  fb_req;
    t_pix     fb_rdata;

    tplm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tplm_fbuf u_fbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fb_req),
        .o_rdata (fb_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer state.
    // ------------------------------------------------------------------
    t_state         r_state, n_state;
    t_op            r_op, n_op;
    logic [2:0]     r_bar, n_bar;
    logic [4:0]     r_cnt, n_cnt;
    logic [2:0]     r_pos, n_pos;
    logic [ROW_W-1:0] r_row, n_row;
    logic           r_flash, n_flash;
    t_pix           r_pat [4];
    logic           r_m_valid, n_m_valid;
    logic [39:0]    r_m_data, n_m_data;

    function automatic t_pix bit_rev(input t_pix v);
        t_pix r;
        for (int i = 0; i < PIX_W; i++) begin
            r[i] = v[PIX_W-1-i];
        end
        return r;
    endfunction

    logic logo_mode;
    assign logo_mode = (r_mode == MODE_LOGO) || (r_mode == MODE_LOGO_BEAT);

    // Track drawing: the current operation decides whether it applies, whether
    // it overwrites a byte or ORs a bit into one, and where.
    logic       mode_lo, mode_pt;
    logic       op_act, op_rmw, op_more;
    t_fb_addr   op_addr;
    t_pix       op_data;
    logic       half;
    logic [2:0] trow;
    logic [2:0] vu_h;
    logic       rot, dot;

    assign mode_lo = (r_mode <= MODE_ROT_DOT);
    assign mode_pt = (r_mode >= MODE_POS_TRK);
    assign half    = r_track[3];
    assign trow    = r_track[2:0];
    assign vu_h    = r_vu[6:4];

    always_comb begin
        op_act  = 1'b0;
        op_rmw  = 1'b0;
        op_more = 1'b0;
        op_addr = '0;
        op_data = '0;
        rot     = 1'b0;
        dot     = 1'b0;
        case (r_op)
            OP_MARK_A, OP_MARK_B: begin
                if (r_op == OP_MARK_A) begin
                    // Red mark in meter and dot modes, green in pos+track modes.
                    op_act = !r_muted && (mode_lo || mode_pt);
                    rot    = (r_mode == MODE_ROT_METER) || (r_mode == MODE_ROT_DOT) ||
                             (r_mode == MODE_ROT_PT);
                    op_addr[3] = mode_lo;
                end else begin
                    op_act = r_sel && mode_pt;
                    rot    = (r_mode == MODE_ROT_PT);
                    op_addr[3] = 1'b1;
                end
                op_addr[4] = half;
                if (rot) begin
                    op_addr[2:0] = trow;
                    op_data      = t_pix'(1) << r_pos;
                end else begin
                    op_rmw       = 1'b1;
                    op_addr[2:0] = 3'd7 - r_pos;
                    op_data      = t_pix'(1) << trow;
                end
            end
            OP_VU: begin
                op_act = (r_vu != '0) && mode_lo;
                rot    = (r_mode == MODE_ROT_METER) || (r_mode == MODE_ROT_DOT);
                dot    = (r_mode == MODE_DOT) || (r_mode == MODE_ROT_DOT);
                op_addr[4] = half;
                op_addr[3] = 1'b0;
                if (rot) begin
                    op_addr[2:0] = trow;
                    op_data      = dot ? (t_pix'(1) << vu_h)
                                       : t_pix'((9'd2 << vu_h) - 9'd1);
                end else begin
                    op_rmw       = 1'b1;
                    op_addr[2:0] = 3'd7 - (dot ? vu_h : r_bar);
                    op_data      = t_pix'(1) << trow;
                    op_more      = !dot && (r_bar < vu_h);
                end
            end
            default: ;
        endcase
    end

    function automatic t_op op_next(input t_op op);
        case (op)
            OP_MARK_A: return OP_MARK_B;
            OP_MARK_B: return OP_VU;
            default:   return OP_DONE;
        endcase
    endfunction

    // Output composition from the four bytes of the shown row.
    logic [7:0] inv_row, inv_pat;
    logic       red_blank;
    logic [39:0] scan_word;

    always_comb begin
        inv_row   = (r_variant == VAR_PLAIN) ? 8'h00 : 8'hff;
        inv_pat   = (r_variant == VAR_INV_ALL) ? 8'hff : 8'h00;
        red_blank = 1'b0;
        if (r_flash) begin
            if (!r_rrc) begin
                inv_pat = ~inv_pat;
            end else begin
                red_blank = 1'b1;
            end
        end
        scan_word[7:0]   = bit_rev(~(t_pix'(1) << r_row) ^ inv_row);
        scan_word[15:8]  = bit_rev(r_pat[0] ^ inv_pat);
        scan_word[23:16] = bit_rev(r_pat[1] ^ inv_pat);
        scan_word[31:24] = red_blank ? inv_pat : bit_rev(r_pat[2] ^ inv_pat);
        scan_word[39:32] = red_blank ? inv_pat : bit_rev(r_pat[3] ^ inv_pat);
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_bar     = r_bar;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_row     = r_row;
        n_flash   = r_flash;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;

        div_req   = '0;
        fb_req    = '0;

        case (r_state)
            ST_IDLE: begin
                if (s_acc && (r_variant != VAR_OFF)) begin
                    case (in_kind)
                        KIND_FRAME: begin
                            if (logo_mode) begin
                                n_cnt   = '0;
                                n_state = ST_LOGO;
                            end else begin
                                fb_req.clr = 1'b1;
                            end
                        end
                        KIND_TRACK: begin
                            if (!logo_mode) begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DIV_DW'({in_step, 3'b000});
                                div_req.divisor  = DIV_SW'({1'b0, in_len} + 9'd1);
                                n_state          = ST_POS;
                            end
                        end
                        KIND_SCAN: begin
                            n_row   = r_row + ROW_W'(1);
                            n_flash = 1'b0;
                            n_cnt   = '0;
                            if ((r_mode == MODE_LOGO_BEAT) && in_run) begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DIV_DW'(in_refstep);
                                div_req.divisor  = DIV_SW'({1'b0, r_spm} + 9'd1);
                                n_state          = ST_SCAN_D1;
                            end else begin
                                n_state = ST_SCAN_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOGO: begin
                fb_req.we   = 1'b1;
                fb_req.addr = r_cnt;
                fb_req.data = r_cnt[4] ? r_logo_r[{r_cnt[2:0], 3'b000} +: 8]
                                       : r_logo_l[{r_cnt[2:0], 3'b000} +: 8];
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(FB_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_POS: begin
                if (div_rsp.done) begin
                    n_pos   = (div_rsp.quotient[DIV_DW-1:3] != '0) ? 3'd7
                                                                 : div_rsp.quotient[2:0];
                    n_op    = OP_MARK_A;
                    n_bar   = '0;
                    n_state = ST_TRK_PLAN;
                end
            end
            ST_TRK_PLAN: begin
                if (r_op == OP_DONE) begin
                    n_state = ST_IDLE;
                end else if (!op_act) begin
                    n_op = op_next(r_op);
                end else if (!op_rmw) begin
                    fb_req.we   = 1'b1;
                    fb_req.addr = op_addr;
                    fb_req.data = op_data;
                    n_op        = op_next(r_op);
                end else begin
                    fb_req.re   = 1'b1;
                    fb_req.addr = op_addr;
                    n_state     = ST_TRK_WR;
                end
            end
            ST_TRK_WR: begin
                fb_req.we   = 1'b1;
                fb_req.addr = op_addr;
                fb_req.data = fb_rdata | op_data;
                if (op_more) begin
                    n_bar = r_bar + 3'd1;
                end else begin
                    n_bar = '0;
                    n_op  = op_next(r_op);
                end
                n_state = ST_TRK_PLAN;
            end
            ST_SCAN_D1: begin
                if (div_rsp.done) begin
                    if (div_rsp.remainder == '0) begin
                        // Start of the measure: flash for the whole step.
                        n_flash = 1'b1;
                        n_state = ST_SCAN_RD;
                    end else if ((r_refstep[1:0] == 2'b00) && (r_ppq != '0)) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = r_tick;
                        div_req.divisor  = r_ppq;
                        n_state          = ST_SCAN_D2;
                    end else begin
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_D2: begin
                if (div_rsp.done) begin
                    // Short flash window on a beat: the first sixteenth of it.
                    n_flash = (div_rsp.remainder < (r_ppq >> 4));
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (r_cnt != 5'd4) begin
                    fb_req.re   = 1'b1;
                    fb_req.addr = {r_cnt[0], r_cnt[1], r_row};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd4) begin
                    n_state = ST_SCAN_OUT;
                end
            end
            ST_SCAN_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = scan_word;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_op      <= OP_MARK_A;
            r_bar     <= '0;
            r_cnt     <= '0;
            r_pos     <= '0;
            r_row     <= '0;
            r_flash   <= 1'b0;
            r_m_valid <= 1'b0;
            r_m_data  <= '0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_bar     <= n_bar;
            r_cnt     <= n_cnt;
            r_pos     <= n_pos;
            r_row     <= n_row;
            r_flash   <= n_flash;
            r_m_valid <= n_m_valid;
            r_m_data  <= n_m_data;
        end
    end

    // Buffer bytes of the shown row, captured in the cycle after each read.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN_RD) && (r_cnt != '0)) begin
            r_pat[2'(r_cnt - 5'd1)] <= fb_rdata;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_div_start_free, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
    `ASSERT_ALWAYS(a_fb_one_access, i_clk, i_rst_n,
        !(fb_req.we && fb_req.re) && !(fb_req.clr && (fb_req.we || fb_req.re)))
    `ASSERT_NEXT(a_scan_busy, i_clk, i_rst_n,
        s_acc && (in_kind == KIND_SCAN) && (r_variant != VAR_OFF), !o_s_tready)
    `ASSERT_IMPL(a_out_no_overrun, i_clk, i_rst_n,
        (r_state == ST_SCAN_OUT) && r_m_valid && !i_m_tready, n_state == ST_SCAN_OUT)

endmodule

`default_nettype wire

/* test/track_position_led_matrix_test.sv */
// Self-checking testbench for the track position LED matrix: stream driver,
// result monitor, APB register writes and a panel predictor.
// Depends on tplm_pkg and the track_position_led_matrix top level.
`default_nettype none

module track_position_led_matrix_test;
    import tplm_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] VAR_INV_ROWS = 2'd3;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Sender and receiver idling patterns.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam int PHASES          = 36;
    localparam int ITEMS_PER_PHASE = 44;
    localparam int PANEL_OFF_PHASE = 17;
    localparam int DRAIN_CYCLES    = 200;
    localparam int HOLD_CYCLES     = 600;
    localparam int CYCLE_LIMIT     = 1000000;

    // One request on the slave stream, with the kind that travels in tuser.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  track;
        logic [7:0]  step;
        logic [7:0]  length;
        logic [7:0]  vu;
        logic        muted;
        logic        selected;
        logic        running;
        logic [7:0]  beat_step;
        logic [31:0] tick;
    } led_req_t;

    // One scan result, laid out as o_m_tdata from the top bit down.
    typedef struct packed {
        logic [7:0] red_right;
        logic [7:0] red_left;
        logic [7:0] green_right;
        logic [7:0] green_left;
        logic [7:0] column;
    } led_scan_t;

    logic        i_clk    = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [5:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [39:0] o_m_tdata;
    wire  [63:0] prdata;
    wire         pready;

    track_position_led_matrix u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: the panel's own frame buffer, scan row and registers.
    // The buffer index is half*16 + colour*8 + row, colour 0 green, 1 red.
    logic [7:0]  fb [32] = '{default: 8'h00};
    logic [2:0]  scan_row      = '0;
    logic [1:0]  cfg_variant   = VAR_OFF;
    logic [2:0]  cfg_mode      = MODE_METER;
    logic [63:0] cfg_logo_l    = '0;
    logic [63:0] cfg_logo_r    = '0;
    logic [7:0]  cfg_spm       = RST_SPM;
    logic [11:0] cfg_ppq       = RST_PPQ;
    logic        cfg_rrc       = RST_RRC;

    led_req_t  req_pending_q [$];
    led_scan_t scan_patterns_q [$];
    led_req_t  s_cur;
    int        idle_mode   = IDLE_NONE;
    int        hold_req    = 0;
    int        hold_seen   = 0;
    int        hold_cnt    = 0;
    int        error_count = 0;
    int        cycle_count = 0;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7 - i] = v[i];
        return r;
    endfunction

    // A position mark either replaces the track's row (rotated layout) or
    // sets the track's bit in the row given by the position (upright).
    task automatic put_mark(input int half, input int colour, input int row, input int pos,
                            input bit rot);
        if (rot) begin
            fb[half * 16 + colour * 8 + row] = 8'(1 << pos);
        end else begin
            fb[half * 16 + colour * 8 + 7 - pos] |= 8'(1 << row);
        end
    endtask

    task automatic led_panel_predict(input led_req_t rq);
        int         half;
        int         row;
        int         pos;
        int         h;
        bit         rot;
        bit         dot;
        bit         flash;
        bit         red_blank;
        logic [7:0] inv_row;
        logic [7:0] inv_pat;
        logic [7:0] sel;
        led_scan_t  e;
        if (cfg_variant == VAR_OFF) return;
        case (rq.kind)
            KIND_FRAME: begin
                if (cfg_mode == MODE_LOGO || cfg_mode == MODE_LOGO_BEAT) begin
                    for (int r = 0; r < ROWS; r++) begin
                        fb[r]      = cfg_logo_l[8 * r +: 8];
                        fb[8 + r]  = cfg_logo_l[8 * r +: 8];
                        fb[16 + r] = cfg_logo_r[8 * r +: 8];
                        fb[24 + r] = cfg_logo_r[8 * r +: 8];
                    end
                end else begin
                    foreach (fb[i]) fb[i] = 8'h00;
                end
            end
            KIND_TRACK: begin
                half = rq.track[3];
                row  = rq.track[2:0];
                pos  = (8 * int'(rq.step)) / (int'(rq.length) + 1);
                if (pos > 7) pos = 7;
                if (cfg_mode <= MODE_ROT_DOT) begin
                    rot = (cfg_mode == MODE_ROT_METER || cfg_mode == MODE_ROT_DOT);
                    dot = (cfg_mode == MODE_DOT || cfg_mode == MODE_ROT_DOT);
                    if (!rq.muted) put_mark(half, 1, row, pos, rot);
                    if (rq.vu != 8'd0) begin
                        h = rq.vu[6:4];
                        if (rot) begin
                            fb[half * 16 + row] = dot ? 8'(1 << h) : 8'((1 << (h + 1)) - 1);
                        end else if (dot) begin
                            fb[half * 16 + 7 - h] |= 8'(1 << row);
                        end else begin
                            for (int i = 0; i <= h; i++) fb[half * 16 + 7 - i] |= 8'(1 << row);
                        end
                    end
                end else if (cfg_mode >= MODE_POS_TRK) begin
                    rot = (cfg_mode == MODE_ROT_PT);
                    if (!rq.muted) put_mark(half, 0, row, pos, rot);
                    if (rq.selected) put_mark(half, 1, row, pos, rot);
                end
            end
            KIND_SCAN: begin
                scan_row = scan_row + 3'd1;
                inv_row  = (cfg_variant == VAR_PLAIN) ? 8'h00 : 8'hff;
                inv_pat  = (cfg_variant == VAR_INV_ALL) ? 8'hff : 8'h00;
                flash    = 1'b0;
                if (cfg_mode == MODE_LOGO_BEAT && rq.running) begin
                    if (int'(rq.beat_step) % (int'(cfg_spm) + 1) == 0) begin
                        flash = 1'b1;
                    end else if (rq.beat_step[1:0] == 2'd0 && cfg_ppq != 12'd0 &&
                                 (rq.tick % {20'd0, cfg_ppq}) < ({20'd0, cfg_ppq} / 32'd16)) begin
                        flash = 1'b1;
                    end
                end
                red_blank = flash && cfg_rrc;
                if (flash && !cfg_rrc) inv_pat = ~inv_pat;
                sel           = ~(8'd1 << scan_row);
                e.column      = mirror8(sel ^ inv_row);
                e.green_left  = mirror8(fb[scan_row] ^ inv_pat);
                e.green_right = mirror8(fb[16 + scan_row] ^ inv_pat);
                e.red_left    = red_blank ? inv_pat : mirror8(fb[8 + scan_row] ^ inv_pat);
                e.red_right   = red_blank ? inv_pat : mirror8(fb[24 + scan_row] ^ inv_pat);
                scan_patterns_q.push_back(e);
            end
            default: ;
        endcase
    endtask

    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 48;
            IDLE_BOTH: return $urandom_range(0, 99) < 13;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 48;
            IDLE_BOTH: return $urandom_range(0, 99) < 13;
            default:   return 1'b0;
        endcase
    endfunction

    // Stream driver. A new request is put up only when the slot is free,
    // that is when nothing is offered or the offered one is taken at this
    // edge, so tvalid gets a single assignment per edge. The predictor sees
    // each request at the edge on which the block accepts it.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_tready) begin
            if (s_tvalid) led_panel_predict(s_cur);
            if (req_pending_q.size() > 0 && !sender_gap()) begin
                s_cur = req_pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, s_cur.tick, s_cur.beat_step, s_cur.running, s_cur.selected,
                             s_cur.muted, s_cur.vu, s_cur.length, s_cur.step, s_cur.track};
                s_tuser  <= s_cur.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver. A hold-off request from the stimulus keeps tready low for a
    // long stretch so that the output register fills and the block stops
    // taking requests while the driver keeps offering them.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            m_tready <= 1'b0;
            if (hold_cnt == HOLD_CYCLES - 1) begin
                hold_cnt  <= 0;
                hold_seen <= hold_req;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end else begin
            m_tready <= !receiver_stall();
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH: %s", what);
        error_count++;
    endtask

    // Result monitor: every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        led_scan_t got;
        led_scan_t e;
        if (rst_n && o_m_tvalid && m_tready) begin
            got = led_scan_t'(o_m_tdata);
            if (scan_patterns_q.size() == 0) begin
                report_mismatch($sformatf("result %h with no prediction pending", o_m_tdata));
            end else begin
                e = scan_patterns_q.pop_front();
                if (got.column !== e.column || got.green_left !== e.green_left ||
                    got.green_right !== e.green_right || got.red_left !== e.red_left ||
                    got.red_right !== e.red_right) begin
                    report_mismatch($sformatf(
                        "col %h/%h gl %h/%h gr %h/%h rl %h/%h rr %h/%h (got/exp)",
                        got.column, e.column, got.green_left, e.green_left,
                        got.green_right, e.green_right, got.red_left, e.red_left,
                        got.red_right, e.red_right));
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // A register write: setup cycle, then the access cycle; the register
    // takes the value at the edge that ends the access cycle, and so does
    // the predictor's copy.
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VARIANT: cfg_variant = val[1:0];
            REG_MODE:    cfg_mode    = val[2:0];
            REG_LOGO_L:  cfg_logo_l  = val;
            REG_LOGO_R:  cfg_logo_r  = val;
            REG_SPM:     cfg_spm     = val[7:0];
            REG_PPQ:     cfg_ppq     = val[11:0];
            REG_RRC:     cfg_rrc     = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] variant, input logic [2:0] mode,
                             input logic [63:0] logo_l, input logic [63:0] logo_r,
                             input logic [7:0] spm, input logic [11:0] ppq, input logic rrc);
        reg_write(REG_VARIANT, {62'd0, variant});
        reg_write(REG_MODE, {61'd0, mode});
        reg_write(REG_LOGO_L, logo_l);
        reg_write(REG_LOGO_R, logo_r);
        reg_write(REG_SPM, {56'd0, spm});
        reg_write(REG_PPQ, {52'd0, ppq});
        reg_write(REG_RRC, {63'd0, rrc});
    endtask

    // Waits until every queued request has been taken and every predicted
    // result has arrived, then lets the block finish any track drawing or
    // logo load that produces no result.
    task automatic drain();
        while (req_pending_q.size() > 0 || s_tvalid || scan_patterns_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random request of a given kind. Scan requests lean towards a running
    // clock and beat-aligned reference steps so that the flash gets hit.
    function automatic led_req_t make_req(input logic [1:0] kind);
        led_req_t rq;
        rq.kind      = kind;
        rq.track     = 4'($urandom);
        rq.step      = 8'($urandom);
        rq.length    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        rq.vu        = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        rq.muted     = ($urandom_range(0, 3) == 0);
        rq.selected  = 1'($urandom);
        rq.running   = ($urandom_range(0, 3) != 0);
        rq.beat_step = 8'($urandom);
        if ($urandom_range(0, 1) == 0) rq.beat_step[1:0] = 2'd0;
        rq.tick      = $urandom;
        return rq;
    endfunction

    // Mostly whole frames (frame start, some tracks, some scans), with a
    // tenth of loose requests of any kind, the unused one included.
    task automatic queue_phase(input int n, input bit scan_heavy);
        int       cnt;
        int       k;
        int       s;
        led_req_t rq;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 9) == 0) begin
                rq = make_req(2'($urandom_range(0, 3)));
                req_pending_q.push_back(rq);
                if (rq.kind != KIND_NONE) cnt++;
            end else begin
                k = $urandom_range(1, 16);
                s = scan_heavy ? 20 : $urandom_range(1, 10);
                req_pending_q.push_back(make_req(KIND_FRAME));
                repeat (k) req_pending_q.push_back(make_req(KIND_TRACK));
                repeat (s) req_pending_q.push_back(make_req(KIND_SCAN));
                cnt += 1 + k + s;
            end
        end
    endtask

    initial begin
        led_req_t    rq;
        logic [1:0]  variant;
        logic [2:0]  mode;
        logic [63:0] logo_l;
        logic [63:0] logo_r;
        logic [7:0]  spm;
        logic [11:0] ppq;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // Straight out of reset the panel is disabled: nothing may come out.
        req_pending_q.push_back(make_req(KIND_FRAME));
        req_pending_q.push_back(make_req(KIND_TRACK));
        req_pending_q.push_back(make_req(KIND_SCAN));
        drain();

        // Upright meter: position extremes, saturation, empty and full bars,
        // a muted track, both halves and the unused kind, then a full scan.
        configure(VAR_PLAIN, MODE_METER, '0, '0, RST_SPM, RST_PPQ, RST_RRC);
        req_pending_q.push_back(make_req(KIND_FRAME));
        rq = make_req(KIND_TRACK);
        rq.track = 4'd0;  rq.step = 8'd0;   rq.length = 8'd0;   rq.vu = 8'd0;   rq.muted = 1'b0;
        req_pending_q.push_back(rq);
        rq.track = 4'd7;  rq.step = 8'd255; rq.length = 8'd0;   rq.vu = 8'hff;
        req_pending_q.push_back(rq);
        rq.track = 4'd8;  rq.step = 8'd255; rq.length = 8'd255; rq.vu = 8'h0f; rq.muted = 1'b1;
        req_pending_q.push_back(rq);
        rq.track = 4'd15; rq.step = 8'd128; rq.length = 8'd255; rq.vu = 8'h80; rq.muted = 1'b0;
        rq.selected = 1'b1;
        req_pending_q.push_back(rq);
        req_pending_q.push_back(make_req(KIND_NONE));
        repeat (8) req_pending_q.push_back(make_req(KIND_SCAN));
        drain();

        // Logo with beat flash: measure start, a beat inside and outside the
        // short window, a stopped clock, and no resolution at all.
        configure(VAR_PLAIN, MODE_LOGO_BEAT, 64'h0123456789abcdef, 64'hfedcba9876543210,
                  RST_SPM, RST_PPQ, RST_RRC);
        req_pending_q.push_back(make_req(KIND_FRAME));
        rq = make_req(KIND_SCAN);
        rq.running = 1'b1; rq.beat_step = 8'd0;  rq.tick = 32'd5;
        req_pending_q.push_back(rq);
        rq.beat_step = 8'd4; rq.tick = 32'd0;
        req_pending_q.push_back(rq);
        rq.tick = 32'd100;
        req_pending_q.push_back(rq);
        rq.running = 1'b0; rq.beat_step = 8'd0;
        req_pending_q.push_back(rq);
        drain();
        configure(VAR_PLAIN, MODE_LOGO_BEAT, 64'h0123456789abcdef, 64'hfedcba9876543210,
                  RST_SPM, 12'd0, RST_RRC);
        rq.running = 1'b1; rq.beat_step = 8'd4; rq.tick = 32'd0;
        req_pending_q.push_back(rq);
        drain();

        // Random phases over every mode and panel variant, the register
        // extremes among them; one phase turns the panel off in between.
        for (int p = 0; p < PHASES; p++) begin
            if (p == PANEL_OFF_PHASE) begin
                variant = VAR_OFF;
            end else begin
                case ((p / 8) % 3)
                    0:       variant = VAR_PLAIN;
                    1:       variant = VAR_INV_ALL;
                    default: variant = VAR_INV_ROWS;
                endcase
            end
            mode    = 3'(p % 8);
            case (p % 4)
                0:       logo_l = '0;
                1:       logo_l = '1;
                default: logo_l = {$urandom, $urandom};
            endcase
            logo_r = (p % 3 == 0) ? ~logo_l : {$urandom, $urandom};
            case (p % 5)
                0:       spm = 8'd0;
                1:       spm = 8'd255;
                2:       spm = RST_SPM;
                3:       spm = 8'd3;
                default: spm = 8'($urandom);
            endcase
            case (p % 7)
                0:       ppq = 12'd0;
                1:       ppq = 12'd1;
                2:       ppq = RST_PPQ;
                3:       ppq = 12'd3840;
                4:       ppq = 12'd4095;
                5:       ppq = 12'($urandom_range(1, 4095));
                default: ppq = 12'd16;
            endcase
            configure(variant, mode, logo_l, logo_r, spm, ppq, 1'((p / 8) % 2));
            idle_mode = (p + p / 8) % 4;
            if (p == 6 || p == 25) hold_req++;
            queue_phase(ITEMS_PER_PHASE, p == 6 || p == 25);
            drain();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/tplm_pkg.sv
rtl/tplm_divider.sv
rtl/tplm_fbuf.sv
rtl/track_position_led_matrix.sv
test/track_position_led_matrix_test.sv
